### sv/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Types and constants shared by the Manchester symbol decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int SymW   = 8;
    localparam int WordW  = 64;
    localparam int CountW = 7;
    localparam int CfgIdxW = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_EXPECT_PULSE_FIRST = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_PAUSE_CODE   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PAUSE_CODE    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_PULSE_CODE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PULSE_CODE    = 3'd4;

    // reset values of the code registers
    localparam logic [SymW-1:0] RST_SHORT_PAUSE = 8'd97;
    localparam logic [SymW-1:0] RST_LONG_PAUSE  = 8'd98;
    localparam logic [SymW-1:0] RST_SHORT_PULSE = 8'd65;
    localparam logic [SymW-1:0] RST_LONG_PULSE  = 8'd66;

    typedef enum logic [1:0] {
        PH_START_PULSE = 2'd0,
        PH_START_PAUSE = 2'd1,
        PH_MID_PULSE   = 2'd2,
        PH_MID_PAUSE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYM_ERR  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [SymW-1:0] symbol;
        logic            last;
    } t_sym_in;

    typedef struct packed {
        logic [WordW-1:0]  bit_word;
        logic [CountW-1:0] bit_count;
        logic [1:0]        status;
    } t_sym_out;

endpackage

### sv/manchester_symbol_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_symbol_decoder_unit
// Decodes classified pulse/pause symbols into Manchester bits, one word per
// packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_stall, i_data) carries one symbol code per word,
//   with last set on the final symbol of a packet. Each symbol updates the
//   phase machine and bit accumulator in the cycle it is accepted.
//   Output channel (o_valid/i_stall, o_data) carries one word per packet:
//   the decoded bits right aligned, the bit count and a status.
//   Configuration port (i_cfg_valid/o_cfg_ready) writes the polarity and
//   symbol code registers; write only while no packet is in flight.
//   Throughput: one symbol per cycle while o_stall is low. The packet word
//   is registered and valid in the cycle after its last symbol is accepted.
//   While the receiver stalls a pending word, o_stall is raised and symbols
//   wait; with the result register empty or draining, symbols flow freely.
//   Reset restores the default codes, closes any open packet and empties
//   the result register.
// ----------------------------------------------------------------------------
module manchester_symbol_decoder_unit #(
    parameter int MAX_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  msd_pkg::t_sym_in                 i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output msd_pkg::t_sym_out                o_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [msd_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [msd_pkg::SymW-1:0]         i_cfg_data
);

    localparam logic [msd_pkg::CountW-1:0] MaxCount = msd_pkg::CountW'(MAX_BITS);

    // configuration
    logic                      r_epf;
    logic [msd_pkg::SymW-1:0]  r_short_pause;
    logic [msd_pkg::SymW-1:0]  r_long_pause;
    logic [msd_pkg::SymW-1:0]  r_short_pulse;
    logic [msd_pkg::SymW-1:0]  r_long_pulse;

    // packet state
    msd_pkg::t_phase             r_phase, n_phase;
    logic                        r_open;
    logic [msd_pkg::WordW-1:0]   r_shift, n_shift;
    logic [msd_pkg::CountW-1:0]  r_total, n_total;
    msd_pkg::t_status            r_fault, n_fault;

    // result register
    logic                r_out_valid;
    msd_pkg::t_sym_out   r_out, n_out;

    logic                        in_acc;
    msd_pkg::t_phase             cur_phase;
    logic [msd_pkg::WordW-1:0]   cur_shift;
    logic [msd_pkg::CountW-1:0]  cur_total;
    msd_pkg::t_status            cur_fault;
    logic                        dec_append;
    logic                        dec_bit;
    logic                        dec_bad;
    logic                        pulse_bit;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign pulse_bit   = r_epf;

    // first symbol of a packet starts from a clean state
    always_comb begin
        if (r_open) begin
            cur_phase = r_phase;
            cur_shift = r_shift;
            cur_total = r_total;
            cur_fault = r_fault;
        end else begin
            cur_phase = r_epf ? msd_pkg::PH_START_PULSE : msd_pkg::PH_START_PAUSE;
            cur_shift = '0;
            cur_total = '0;
            cur_fault = msd_pkg::ST_OK;
        end
    end

    // next phase
    always_comb begin
        n_phase = cur_phase;
        if (cur_fault != msd_pkg::ST_SYM_ERR) begin
            case (cur_phase)
                msd_pkg::PH_START_PULSE: begin
                    if (i_data.symbol == r_short_pulse) n_phase = msd_pkg::PH_MID_PAUSE;
                end
                msd_pkg::PH_START_PAUSE: begin
                    if (i_data.symbol == r_short_pause) n_phase = msd_pkg::PH_MID_PULSE;
                end
                msd_pkg::PH_MID_PULSE: begin
                    if (i_data.symbol == r_short_pulse)
                        n_phase = msd_pkg::PH_START_PAUSE;
                    else if (i_data.symbol == r_long_pulse)
                        n_phase = msd_pkg::PH_MID_PAUSE;
                end
                msd_pkg::PH_MID_PAUSE: begin
                    if (i_data.symbol == r_short_pause)
                        n_phase = msd_pkg::PH_START_PULSE;
                    else if (i_data.symbol == r_long_pause)
                        n_phase = msd_pkg::PH_MID_PULSE;
                end
                default: n_phase = cur_phase;
            endcase
        end
    end

    // decode outputs: append a bit or flag a bad symbol
    always_comb begin
        dec_append = 1'b0;
        dec_bit    = pulse_bit;
        dec_bad    = 1'b0;
        case (cur_phase)
            msd_pkg::PH_START_PULSE: begin
                if (i_data.symbol == r_short_pulse) dec_append = 1'b1;
                else dec_bad = 1'b1;
            end
            msd_pkg::PH_START_PAUSE: begin
                dec_bit = ~pulse_bit;
                if (i_data.symbol == r_short_pause) dec_append = 1'b1;
                else dec_bad = 1'b1;
            end
            msd_pkg::PH_MID_PULSE: begin
                if (i_data.symbol == r_short_pulse) dec_append = 1'b0;
                else if (i_data.symbol == r_long_pulse) dec_append = 1'b1;
                else dec_bad = 1'b1;
            end
            msd_pkg::PH_MID_PAUSE: begin
                dec_bit = ~pulse_bit;
                if (i_data.symbol == r_short_pause) dec_append = 1'b0;
                else if (i_data.symbol == r_long_pause) dec_append = 1'b1;
                else dec_bad = 1'b1;
            end
            default: dec_bad = 1'b1;
        endcase
    end

    // accumulator and result
    always_comb begin
        n_shift = cur_shift;
        n_total = cur_total;
        n_fault = cur_fault;
        if (cur_fault != msd_pkg::ST_SYM_ERR) begin
            if (dec_bad) begin
                n_fault = msd_pkg::ST_SYM_ERR;
            end else if (dec_append) begin
                if (cur_total >= MaxCount) begin
                    // drop the bit, keep decoding pairs
                    if (cur_fault == msd_pkg::ST_OK) n_fault = msd_pkg::ST_OVERFLOW;
                end else begin
                    n_shift = {cur_shift[msd_pkg::WordW-2:0], dec_bit};
                    n_total = cur_total + msd_pkg::CountW'(1);
                end
            end
        end
        if (n_fault == msd_pkg::ST_SYM_ERR) begin
            n_out.bit_word  = '0;
            n_out.bit_count = '0;
        end else begin
            n_out.bit_word  = n_shift;
            n_out.bit_count = n_total;
        end
        n_out.status = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epf         <= 1'b1;
            r_short_pause <= msd_pkg::RST_SHORT_PAUSE;
            r_long_pause  <= msd_pkg::RST_LONG_PAUSE;
            r_short_pulse <= msd_pkg::RST_SHORT_PULSE;
            r_long_pulse  <= msd_pkg::RST_LONG_PULSE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                msd_pkg::CFG_EXPECT_PULSE_FIRST: r_epf         <= i_cfg_data[0];
                msd_pkg::CFG_SHORT_PAUSE_CODE:   r_short_pause <= i_cfg_data;
                msd_pkg::CFG_LONG_PAUSE_CODE:    r_long_pause  <= i_cfg_data;
                msd_pkg::CFG_SHORT_PULSE_CODE:   r_short_pulse <= i_cfg_data;
                msd_pkg::CFG_LONG_PULSE_CODE:    r_long_pulse  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_phase     <= msd_pkg::PH_START_PULSE;
            r_total     <= '0;
            r_fault     <= msd_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_open  <= ~i_data.last;
                r_phase <= n_phase;
                r_total <= n_total;
                r_fault <= n_fault;
            end
            if (in_acc && i_data.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_shift <= n_shift;
        end
        if (in_acc && i_data.last) begin
            r_out <= n_out;
        end
    end

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == msd_pkg::ST_SYM_ERR)
            |-> (o_data.bit_count == '0 && o_data.bit_word == '0))
        else $error("symbol error word carries bits");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == msd_pkg::ST_OVERFLOW) |-> (o_data.bit_count == MaxCount))
        else $error("overflow word not full");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MaxCount)
        else $error("bit total beyond limit");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.last) |=> o_valid)
        else $error("last symbol gave no result");

endmodule
